### design/fdmc_pkg.sv
package fdmc_pkg;

  // item and state widths
  localparam int PIX_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 11;
  localparam int SUM_W     = 32;
  localparam int COUNT_W   = 22;
  localparam int CENT_W    = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CENT_W-1:0]  CENT_MAX  = {CENT_W{1'b1}};

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // register reset values
  localparam logic [CHAN_W-1:0] RST_THRESHOLD    = 8'd10;
  localparam logic              RST_UPDATE_REF   = 1'b1;
  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD,
    REG_UPDATE_REF,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

endpackage

### design/fdmc_ref_mem.sv
module fdmc_ref_mem #(
  parameter int DEPTH  = fdmc_pkg::DEF_MAX_WIDTH * fdmc_pkg::DEF_MAX_HEIGHT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [fdmc_pkg::PIX_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [fdmc_pkg::PIX_W-1:0] wr_data
);

  logic [fdmc_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/fdmc_div.sv
module fdmc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fdmc_pkg::SUM_W-1:0]   dividend,
  input  logic [fdmc_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [fdmc_pkg::CENT_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(fdmc_pkg::SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fdmc_pkg::SUM_W - 1);

  logic                         busy;
  logic [STEP_W-1:0]            step;
  logic [fdmc_pkg::SUM_W-1:0]   quo;
  logic [fdmc_pkg::COUNT_W-1:0] rem;
  logic [fdmc_pkg::COUNT_W-1:0] den;
  logic [fdmc_pkg::COUNT_W:0]   trial;
  logic [fdmc_pkg::COUNT_W:0]   trial_sub;
  logic                         fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial     = {rem, quo[fdmc_pkg::SUM_W-1]};
    trial_sub = trial - {1'b0, den};
    fits      = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[fdmc_pkg::SUM_W-2:0], fits};
      rem <= fits ? trial_sub[fdmc_pkg::COUNT_W-1:0] : trial[fdmc_pkg::COUNT_W-1:0];
    end
  end

  // saturate to the centroid range
  assign quotient = (|quo[fdmc_pkg::SUM_W-1:fdmc_pkg::CENT_W]) ? fdmc_pkg::CENT_MAX
                                                                 : quo[fdmc_pkg::CENT_W-1:0];

endmodule

### design/frame_diff_motion_centroid.sv
// Frame-difference motion detector with change centroid.
// Each pixel steps through IDLE (accept and reference read), COMPARE (compare and
// write-back) and OUTPUT (output load); the last pixel of a frame also waits in
// DIVIDE on the two 32-step centroid dividers. A new pixel is taken only after the
// previous one is loaded into the output register, so output stalls hold off input.
// Reset: clears control, indices and sums, count to 1, config to defaults; reference memory kept.
module frame_diff_motion_centroid #(
  parameter int MAX_WIDTH  = fdmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdmc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [fdmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdmc_pkg::CFG_W-1:0]     cfg_data,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fdmc_pkg::CHAN_W-1:0]    blue,
  input  logic [fdmc_pkg::CHAN_W-1:0]    green,
  input  logic [fdmc_pkg::CHAN_W-1:0]    red,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           changed_red,
  output logic                           changed_green,
  output logic                           changed_blue,
  output logic [fdmc_pkg::CENT_W-1:0]    centroid_x,
  output logic [fdmc_pkg::CENT_W-1:0]    centroid_y,
  output logic                           frame_end
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MAX_WH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SZ_W0  = $clog2(MAX_WH) + 1;
  localparam int SZ_W   = (SZ_W0 > fdmc_pkg::CFG_W) ? SZ_W0 : fdmc_pkg::CFG_W;
  localparam int CXN_W  = COL_W + 2;
  localparam int RXN_W  = ROW_W + 2;

  localparam logic [SZ_W-1:0]   SZ_MAX_W   = SZ_W'(MAX_WIDTH);
  localparam logic [SZ_W-1:0]   SZ_MAX_H   = SZ_W'(MAX_HEIGHT);
  localparam logic [SZ_W-1:0]   SZ_ONE     = SZ_W'(1);
  localparam logic [ADDR_W-1:0] LINE_STEP  = ADDR_W'(MAX_WIDTH);

  // configuration registers
  logic [fdmc_pkg::CHAN_W-1:0] threshold;
  logic                        update_reference;
  logic [fdmc_pkg::CFG_W-1:0]  frame_width;
  logic [fdmc_pkg::CFG_W-1:0]  frame_height;

  // frame state
  fdmc_pkg::state_t             state, state_next;
  logic                         reference_loaded;
  logic [COL_W-1:0]             column_index;
  logic [ROW_W-1:0]             row_index;
  logic [ADDR_W-1:0]            line_base;
  logic [fdmc_pkg::SUM_W-1:0]   column_sum;
  logic [fdmc_pkg::SUM_W-1:0]   row_sum;
  logic [fdmc_pkg::COUNT_W-1:0] change_count;
  logic [fdmc_pkg::PIX_W-1:0]   pixel;

  // result held until the output register is free
  logic [2:0]                   res_changed;   // {red, green, blue}
  logic [fdmc_pkg::CENT_W-1:0]  res_cx;
  logic [fdmc_pkg::CENT_W-1:0]  res_cy;
  logic                         res_end;

  // FSM outputs
  logic in_accept;
  logic rd_en;
  logic wr_en;
  logic div_start;
  logic out_load;

  // datapath
  logic [ADDR_W-1:0]            addr;
  logic [fdmc_pkg::PIX_W-1:0]   rd_data;
  logic [fdmc_pkg::PIX_W-1:0]   ref_word;
  logic [2:0]                   chg;
  logic [1:0]                   n_chg;
  logic [CXN_W-1:0]             col_x_n;
  logic [RXN_W-1:0]             row_x_n;
  logic [fdmc_pkg::SUM_W-1:0]   column_sum_next;
  logic [fdmc_pkg::SUM_W-1:0]   row_sum_next;
  logic [fdmc_pkg::COUNT_W:0]   count_inc;
  logic [fdmc_pkg::COUNT_W-1:0] change_count_next;
  logic [SZ_W-1:0]              width_use;
  logic [SZ_W-1:0]              height_use;
  logic                         line_end;
  logic                         frame_last;
  logic                         div_x_done;
  logic                         div_y_done;
  logic [fdmc_pkg::CENT_W-1:0]  quo_x;
  logic [fdmc_pkg::CENT_W-1:0]  quo_y;

  // ---------------------------------------------------------------------------
  // Configuration port, no handshake: the user must write it only while the block is idle; not enforced.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= fdmc_pkg::RST_THRESHOLD;
      update_reference <= fdmc_pkg::RST_UPDATE_REF;
      frame_width      <= fdmc_pkg::RST_FRAME_WIDTH;
      frame_height     <= fdmc_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      unique case (fdmc_pkg::cfg_reg_t'(cfg_index))
        fdmc_pkg::REG_THRESHOLD:    threshold        <= cfg_data[fdmc_pkg::CHAN_W-1:0];
        fdmc_pkg::REG_UPDATE_REF:   update_reference <= cfg_data[0];
        fdmc_pkg::REG_FRAME_WIDTH:  frame_width      <= cfg_data;
        fdmc_pkg::REG_FRAME_HEIGHT: frame_height     <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame geometry. A size of 0 acts as 1, above the maximum as the maximum.
  // Indices never pass the maximum, so no clamp is needed on them.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (frame_width == '0) begin
      width_use = SZ_ONE;
    end else if (SZ_W'(frame_width) > SZ_MAX_W) begin
      width_use = SZ_MAX_W;
    end else begin
      width_use = SZ_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_use = SZ_ONE;
    end else if (SZ_W'(frame_height) > SZ_MAX_H) begin
      height_use = SZ_MAX_H;
    end else begin
      height_use = SZ_W'(frame_height);
    end
    line_end   = (SZ_W'(column_index) + SZ_ONE) >= width_use;
    frame_last = line_end && ((SZ_W'(row_index) + SZ_ONE) >= height_use);
  end

  // address kept as line base plus column, avoiding a row multiply
  assign addr = line_base + ADDR_W'(column_index);

  // ---------------------------------------------------------------------------
  // Reference memory: read on accept, compared and written back next cycle.
  // Only one item is in flight, so read and write never overlap on an entry.
  // The first frame after reset is compared with itself and stored.
  // ---------------------------------------------------------------------------
  fdmc_ref_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ref_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (pixel)
  );

  // Before the first frame has been stored the pixel is its own reference.
  assign ref_word = reference_loaded ? rd_data : pixel;

  // ---------------------------------------------------------------------------
  // Compare and accumulate. Every changed channel adds the column and row once
  // and bumps the count, so the sums take col*n and row*n with n up to three.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [fdmc_pkg::CHAN_W-1:0] cur_c;
    logic [fdmc_pkg::CHAN_W-1:0] ref_c;
    logic [fdmc_pkg::CHAN_W-1:0] diff;
    for (int i = 0; i < 3; i++) begin
      cur_c  = pixel[i*fdmc_pkg::CHAN_W +: fdmc_pkg::CHAN_W];
      ref_c  = ref_word[i*fdmc_pkg::CHAN_W +: fdmc_pkg::CHAN_W];
      diff   = (cur_c >= ref_c) ? (cur_c - ref_c) : (ref_c - cur_c);
      chg[i] = diff > threshold;
    end
    n_chg   = 2'(chg[0]) + 2'(chg[1]) + 2'(chg[2]);
    col_x_n = (n_chg[0] ? CXN_W'(column_index) : '0)
            + (n_chg[1] ? {1'b0, column_index, 1'b0} : '0);
    row_x_n = (n_chg[0] ? RXN_W'(row_index) : '0)
            + (n_chg[1] ? {1'b0, row_index, 1'b0} : '0);
    column_sum_next = column_sum + fdmc_pkg::SUM_W'(col_x_n);
    row_sum_next    = row_sum + fdmc_pkg::SUM_W'(row_x_n);
    // saturating count
    count_inc = {1'b0, change_count} + (fdmc_pkg::COUNT_W + 1)'(n_chg);
    change_count_next = (count_inc > {1'b0, fdmc_pkg::COUNT_MAX})
                        ? fdmc_pkg::COUNT_MAX
                        : count_inc[fdmc_pkg::COUNT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Centroid dividers, started with the final sums on the last pixel.
  // ---------------------------------------------------------------------------
  fdmc_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (column_sum_next),
    .divisor  (change_count_next),
    .done     (div_x_done),
    .quotient (quo_x)
  );

  fdmc_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (row_sum_next),
    .divisor  (change_count_next),
    .done     (div_y_done),
    .quotient (quo_y)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes an item and issues the read, COMPARE writes back
  // (on the first frame or with refresh on), steps the indices and on a frame's
  // last pixel starts the dividers, DIVIDE waits on the dividers, OUTPUT hands
  // the result to the output register once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fdmc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
        if (in_valid) begin
          state_next = fdmc_pkg::ST_COMPARE;
        end
      end
      fdmc_pkg::ST_COMPARE: begin
        wr_en = !reference_loaded || update_reference;
        if (frame_last) begin
          div_start  = 1'b1;
          state_next = fdmc_pkg::ST_DIVIDE;
        end else begin
          state_next = fdmc_pkg::ST_OUTPUT;
        end
      end
      fdmc_pkg::ST_DIVIDE: begin
        if (div_x_done && div_y_done) begin
          state_next = fdmc_pkg::ST_OUTPUT;
        end
      end
      fdmc_pkg::ST_OUTPUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = fdmc_pkg::ST_IDLE;
        end
      end
      default: state_next = fdmc_pkg::ST_IDLE;
    endcase
  end

  assign in_accept = in_ready && in_valid;

  // frame state: indices, sums, count, loaded flag
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_loaded <= 1'b0;
      column_index     <= '0;
      row_index        <= '0;
      line_base        <= '0;
      column_sum       <= '0;
      row_sum          <= '0;
      change_count     <= fdmc_pkg::COUNT_W'(1);
    end else if (state == fdmc_pkg::ST_COMPARE) begin
      if (frame_last) begin
        reference_loaded <= 1'b1;
        column_index     <= '0;
        row_index        <= '0;
        line_base        <= '0;
        column_sum       <= '0;
        row_sum          <= '0;
        change_count     <= fdmc_pkg::COUNT_W'(1);
      end else begin
        column_sum   <= column_sum_next;
        row_sum      <= row_sum_next;
        change_count <= change_count_next;
        if (line_end) begin
          column_index <= '0;
          row_index    <= row_index + 1'b1;
          line_base    <= line_base + LINE_STEP;
        end else begin
          column_index <= column_index + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pixel <= {red, green, blue};
    end
    if (state == fdmc_pkg::ST_COMPARE) begin
      res_changed <= {chg[2], chg[1], chg[0]};
      res_end     <= frame_last;
      res_cx      <= '0;
      res_cy      <= '0;
    end else if (state == fdmc_pkg::ST_DIVIDE && div_x_done && div_y_done) begin
      res_cx <= quo_x;
      res_cy <= quo_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      changed_red   <= res_changed[2];
      changed_green <= res_changed[1];
      changed_blue  <= res_changed[0];
      centroid_x    <= res_cx;
      centroid_y    <= res_cy;
      frame_end     <= res_end;
    end
  end

endmodule

### bench/frame_diff_motion_centroid_test.sv
module frame_diff_motion_centroid_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Area loaded by the first frame after reset. Every later visit stays inside
  // it, so no reference entry is ever read before it has been written.
  localparam int AREA_W      = 12;
  localparam int AREA_H      = 8;
  localparam int RANDOM_PIX  = 1230;
  localparam int CALM_FROM   = 1030;   // random items after which idling stops
  localparam int CYCLE_LIMIT = 400000;

  // pixel content relative to the stored reference
  typedef enum {
    FILL_NEAR,      // channel offsets around the threshold
    FILL_RANDOM,
    FILL_EXTREME    // 0 or 255 only
  } fill_t;

  typedef struct packed {
    logic                        changed_red;
    logic                        changed_green;
    logic                        changed_blue;
    logic [fdmc_pkg::CENT_W-1:0] centroid_x;
    logic [fdmc_pkg::CENT_W-1:0] centroid_y;
    logic                        frame_end;
  } motion_report_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [fdmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fdmc_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [fdmc_pkg::CHAN_W-1:0]    blue = '0;
  logic [fdmc_pkg::CHAN_W-1:0]    green = '0;
  logic [fdmc_pkg::CHAN_W-1:0]    red = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           changed_red;
  logic                           changed_green;
  logic                           changed_blue;
  logic [fdmc_pkg::CENT_W-1:0]    centroid_x;
  logic [fdmc_pkg::CENT_W-1:0]    centroid_y;
  logic                           frame_end;

  frame_diff_motion_centroid uut (.*);

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Motion predictor: own copy of the registers and of the detector state
  // ---------------------------------------------------------------------------
  logic [fdmc_pkg::CHAN_W-1:0] thr_cfg    = fdmc_pkg::RST_THRESHOLD;
  logic                        upd_cfg    = fdmc_pkg::RST_UPDATE_REF;
  logic [fdmc_pkg::CFG_W-1:0]  width_cfg  = fdmc_pkg::RST_FRAME_WIDTH;
  logic [fdmc_pkg::CFG_W-1:0]  height_cfg = fdmc_pkg::RST_FRAME_HEIGHT;

  logic [fdmc_pkg::PIX_W-1:0]  prior_frame [int];   // stored BGR words, row*1024+col
  bit                          ref_loaded   = 1'b0;
  int                          col_pos      = 0;
  int                          row_pos      = 0;
  bit [fdmc_pkg::SUM_W-1:0]    col_sum      = '0;
  bit [fdmc_pkg::SUM_W-1:0]    row_sum      = '0;
  bit [fdmc_pkg::COUNT_W-1:0]  change_count = 1;
  bit                          frame_closed = 1'b0;  // last predicted item ended a frame

  motion_report_t     pending_reports [$];

  int errors        = 0;
  int pixels_sent   = 0;
  int frames_done   = 0;
  int motion_frames = 0;
  int reg_writes    = 0;
  int gap_pct       = 0;   // sender idling, percent of items
  int stall_pct     = 0;   // receiver idling, percent of cycles
  int stall_left    = 0;
  int cycle_count   = 0;

  // zero acts as one, oversize acts as the maximum
  function automatic int clamp_dim(input logic [fdmc_pkg::CFG_W-1:0] v, input int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic logic [fdmc_pkg::CENT_W-1:0] centroid_of(
      input bit [fdmc_pkg::SUM_W-1:0] sum, input bit [fdmc_pkg::COUNT_W-1:0] cnt);
    bit [fdmc_pkg::SUM_W-1:0] q;
    q = sum / fdmc_pkg::SUM_W'(cnt);
    return (q > fdmc_pkg::SUM_W'(fdmc_pkg::CENT_MAX)) ? fdmc_pkg::CENT_MAX
                                                       : q[fdmc_pkg::CENT_W-1:0];
  endfunction

  task automatic predict_motion(input logic [fdmc_pkg::PIX_W-1:0] pix);
    int                         wd, ht, addr, diff, i;
    logic [fdmc_pkg::PIX_W-1:0] refw;
    logic [2:0]                 hit;    // bit 0 blue, 1 green, 2 red
    bit                         line_end;
    motion_report_t             rep;
    wd   = clamp_dim(width_cfg, fdmc_pkg::DEF_MAX_WIDTH);
    ht   = clamp_dim(height_cfg, fdmc_pkg::DEF_MAX_HEIGHT);
    addr = row_pos * fdmc_pkg::DEF_MAX_WIDTH + col_pos;
    // first frame compares each pixel with itself
    if (!ref_loaded) refw = pix;
    else if (prior_frame.exists(addr)) refw = prior_frame[addr];
    else refw = '0;
    for (i = 0; i < 3; i++) begin
      diff = int'(pix[8*i +: 8]) - int'(refw[8*i +: 8]);
      if (diff < 0) diff = -diff;
      hit[i] = (diff > int'(thr_cfg));
      if (hit[i]) begin
        col_sum = col_sum + fdmc_pkg::SUM_W'(col_pos);
        row_sum = row_sum + fdmc_pkg::SUM_W'(row_pos);
        if (change_count != fdmc_pkg::COUNT_MAX) change_count = change_count + 1'b1;
      end
    end
    if (!ref_loaded || upd_cfg) prior_frame[addr] = pix;

    line_end     = (col_pos + 1 >= wd);
    frame_closed = line_end && (row_pos + 1 >= ht);

    rep.changed_red   = hit[2];
    rep.changed_green = hit[1];
    rep.changed_blue  = hit[0];
    rep.centroid_x    = frame_closed ? centroid_of(col_sum, change_count) : '0;
    rep.centroid_y    = frame_closed ? centroid_of(row_sum, change_count) : '0;
    rep.frame_end     = frame_closed;
    pending_reports.push_back(rep);

    if (frame_closed) begin
      frames_done++;
      if (change_count > 1) motion_frames++;
      col_pos      = 0;
      row_pos      = 0;
      col_sum      = '0;
      row_sum      = '0;
      change_count = 1;
      ref_loaded   = 1'b1;
    end else if (line_end) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [fdmc_pkg::CENT_W-1:0] want,
                             input logic [fdmc_pkg::CENT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_report;
    motion_report_t want;
    if (pending_reports.size() == 0) begin
      errors++;
      $display("%0t: result item with none expected (x %0d, y %0d, end %0b)",
               $time, centroid_x, centroid_y, frame_end);
    end else begin
      want = pending_reports.pop_front();
      check_field("changed_red", want.changed_red, changed_red);
      check_field("changed_green", want.changed_green, changed_green);
      check_field("changed_blue", want.changed_blue, changed_blue);
      check_field("centroid_x", want.centroid_x, centroid_x);
      check_field("centroid_y", want.centroid_y, centroid_y);
      check_field("frame_end", want.frame_end, frame_end);
    end
  endtask

  // values sampled here are those the block saw at this edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_report();
  end

  // receiver: out_ready drops in stall bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left on a rising edge
  // ---------------------------------------------------------------------------
  function automatic logic [fdmc_pkg::CHAN_W-1:0] pick_channel(
      input logic [fdmc_pkg::CHAN_W-1:0] base, input fill_t fill);
    int d, v;
    if (fill == FILL_EXTREME) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if (fill == FILL_RANDOM) return fdmc_pkg::CHAN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       d = 0;
      1:       d = int'(thr_cfg);          // just inside: not flagged
      2:       d = int'(thr_cfg) + 1;      // just outside: flagged
      3:       d = $urandom_range(0, 2 * int'(thr_cfg) + 2);
      default: return fdmc_pkg::CHAN_W'($urandom_range(0, 255));
    endcase
    v = $urandom_range(0, 1) ? int'(base) + d : int'(base) - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return fdmc_pkg::CHAN_W'(v);
  endfunction

  task automatic send_pixel(input fill_t fill);
    logic [fdmc_pkg::PIX_W-1:0] base, pix;
    int                         addr, i;
    addr = row_pos * fdmc_pkg::DEF_MAX_WIDTH + col_pos;
    base = prior_frame.exists(addr) ? prior_frame[addr] : fdmc_pkg::PIX_W'($urandom);
    for (i = 0; i < 3; i++) pix[8*i +: 8] = pick_channel(base[8*i +: 8], fill);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    blue     <= pix[7:0];
    green    <= pix[15:8];
    red      <= pix[23:16];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_motion(pix);
    pixels_sent++;
  endtask

  task automatic send_frame(input fill_t fill);
    do send_pixel(fill); while (!frame_closed);
  endtask

  // sender holds off until every expected result has come back; it always waits
  // on an edge first, so valid never takes two assignments in one step
  task automatic drain_reports;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // one write, then a wait with the strobe low so it never rises and falls in one step
  task automatic write_reg(input fdmc_pkg::cfg_reg_t idx,
                           input logic [fdmc_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fdmc_pkg::REG_THRESHOLD:    thr_cfg    = val[fdmc_pkg::CHAN_W-1:0];
      fdmc_pkg::REG_UPDATE_REF:   upd_cfg    = val[0];
      fdmc_pkg::REG_FRAME_WIDTH:  width_cfg  = val;
      fdmc_pkg::REG_FRAME_HEIGHT: height_cfg = val;
      default:                    ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // unused upper bits of the data bus carry noise
  task automatic write_threshold(input logic [fdmc_pkg::CHAN_W-1:0] t);
    write_reg(fdmc_pkg::REG_THRESHOLD, {3'($urandom_range(0, 7)), t});
  endtask

  task automatic write_update(input bit u);
    write_reg(fdmc_pkg::REG_UPDATE_REF, {10'($urandom_range(0, 1023)), u});
  endtask

  task automatic write_size(input logic [fdmc_pkg::CFG_W-1:0] w,
                            input logic [fdmc_pkg::CFG_W-1:0] h);
    write_reg(fdmc_pkg::REG_FRAME_WIDTH, w);
    write_reg(fdmc_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First frame after reset: starts at the reset size, then is cut down to
  // the working area while idle. Nothing can be flagged; every pixel is stored.
  task automatic test_first_frame;
    repeat (AREA_W - 1) send_pixel(FILL_EXTREME);
    drain_reports();
    write_size(fdmc_pkg::CFG_W'(AREA_W), fdmc_pkg::CFG_W'(AREA_H));
    send_frame(FILL_EXTREME);
    drain_reports();
  endtask

  // reset threshold and refresh still in force
  task automatic test_defaults;
    write_size(11'd2, 11'd2);
    send_frame(FILL_NEAR);
    drain_reports();
  endtask

  // 255 can never be exceeded; 0 flags any difference at all
  task automatic test_threshold_extremes;
    write_threshold(8'hFF);
    send_frame(FILL_EXTREME);
    drain_reports();
    write_threshold(8'h00);
    send_frame(FILL_NEAR);
    drain_reports();
  endtask

  // with refresh off the reference keeps its old content
  task automatic test_reference_hold;
    write_update(1'b0);
    write_threshold(8'd5);
    write_size(11'd2, 11'd1);
    repeat (3) send_frame(FILL_NEAR);
    drain_reports();
    write_update(1'b1);
  endtask

  // Oversize and zero sizes, and sizes cut mid-frame so that the current
  // column or row is already past the new end.
  task automatic test_size_limits;
    write_reg(fdmc_pkg::REG_FRAME_HEIGHT, 11'd0);
    write_reg(fdmc_pkg::REG_FRAME_WIDTH, 11'h7FF);
    repeat (3) send_pixel(FILL_NEAR);
    drain_reports();
    write_reg(fdmc_pkg::REG_FRAME_WIDTH, 11'd1024);
    repeat (2) send_pixel(FILL_NEAR);
    drain_reports();
    write_reg(fdmc_pkg::REG_FRAME_WIDTH, 11'd1);
    send_pixel(FILL_NEAR);              // column 5 ends line and frame
    drain_reports();

    write_reg(fdmc_pkg::REG_FRAME_WIDTH, 11'd0);
    write_reg(fdmc_pkg::REG_FRAME_HEIGHT, 11'd1024);
    repeat (2) send_pixel(FILL_NEAR);
    drain_reports();
    write_reg(fdmc_pkg::REG_FRAME_HEIGHT, 11'h7FF);
    repeat (2) send_pixel(FILL_NEAR);
    drain_reports();
    write_reg(fdmc_pkg::REG_FRAME_HEIGHT, 11'd3);
    send_pixel(FILL_NEAR);              // row 4 is past the last line
    drain_reports();
  endtask

  // Phases of random length, often ending mid-frame; between phases the
  // registers are rewritten while idle and the idling pattern is redrawn.
  task automatic test_random_traffic;
    int sent, n, k;
    sent = 0;
    while (sent < RANDOM_PIX) begin
      drain_reports();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       write_threshold($urandom_range(0, 1) ? 8'hFF : 8'h00);
          1:       write_threshold(fdmc_pkg::CHAN_W'($urandom_range(0, 255)));
          default: write_threshold(fdmc_pkg::CHAN_W'($urandom_range(0, 24)));
        endcase
      end
      if ($urandom_range(0, 1)) write_update($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        write_size(fdmc_pkg::CFG_W'($urandom_range(0, AREA_W)),
                   fdmc_pkg::CFG_W'($urandom_range(0, AREA_H)));
      end

      if (sent >= CALM_FROM) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        k         = $urandom_range(0, 3);
        gap_pct   = k[0] ? $urandom_range(5, 40) : 0;
        stall_pct = k[1] ? $urandom_range(5, 40) : 0;
      end

      n = $urandom_range(1, 90);
      if (n > RANDOM_PIX - sent) n = RANDOM_PIX - sent;
      repeat (n) begin
        k = $urandom_range(0, 9);
        send_pixel(k < 7 ? FILL_NEAR : (k < 9 ? FILL_RANDOM : FILL_EXTREME));
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_first_frame();
    gap_pct   = 20;
    stall_pct = 20;
    test_defaults();
    test_threshold_extremes();
    test_reference_hold();
    test_size_limits();
    test_random_traffic();

    // last results, then room for anything stray
    drain_reports();
    repeat (60) @(posedge clk);

    $display("Ran %0d pixels over %0d frames, %0d of them with change, %0d register writes.",
             pixels_sent, frames_done, motion_frames, reg_writes);
    $display("Covered first-frame load, threshold and size limits, reference hold,");
    $display("mid-frame resizing and random traffic with idling on both sides.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/fdmc_pkg.sv
design/fdmc_ref_mem.sv
design/fdmc_div.sv
design/frame_diff_motion_centroid.sv
bench/frame_diff_motion_centroid_test.sv
